FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, action codes and the queued work item of the fixed-point
// ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_W    = 32;
    // dividend magnitude shifted left by the fraction bits
    localparam int DIV_W     = WORD_W + FRAC_BITS;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [4:0] ACT_ADD      = 5'd0;
    localparam logic [4:0] ACT_SUB      = 5'd1;
    localparam logic [4:0] ACT_MUL      = 5'd2;
    localparam logic [4:0] ACT_DIV      = 5'd3;
    localparam logic [4:0] ACT_NEG      = 5'd4;
    localparam logic [4:0] ACT_INC      = 5'd5;
    localparam logic [4:0] ACT_DEC      = 5'd6;
    localparam logic [4:0] ACT_EQ       = 5'd7;
    localparam logic [4:0] ACT_NE       = 5'd8;
    localparam logic [4:0] ACT_GE       = 5'd9;
    localparam logic [4:0] ACT_LE       = 5'd10;
    localparam logic [4:0] ACT_GT       = 5'd11;
    localparam logic [4:0] ACT_LT       = 5'd12;
    localparam logic [4:0] ACT_MIN      = 5'd13;
    localparam logic [4:0] ACT_MAX      = 5'd14;
    localparam logic [4:0] ACT_FROM_INT = 5'd15;
    localparam logic [4:0] ACT_TO_INT   = 5'd16;

    // which back-end unit produces the result
    typedef enum logic [1:0] {
        KIND_ALU = 2'd0,
        KIND_MUL = 2'd1,
        KIND_DIV = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  res;   // finished result for ALU kind
        logic               cmp;
        logic               derr;
        logic signed [WORD_W-1:0] a;
        logic signed [WORD_W-1:0] b;
        logic [WORD_W-1:0]  dvd;   // dividend magnitude
        logic [WORD_W-1:0]  dvs;   // divisor magnitude
        logic               neg;   // quotient sign
    } fpa_item_t;

endpackage
`default_nettype wire

FILE: rtl/fpa_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_ifs
// Valid/ready channels for the fixed-point ALU command and response beats.
// ----------------------------------------------------------------------------
interface fpa_cmd_if;
    logic               valid;
    logic               ready;
    logic [4:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, action, operand_a, operand_b, input ready);
    modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_word;
    logic               compare_true;
    logic               divide_error;

    modport source (output valid, result_word, compare_true, divide_error,
                    input ready);
    modport sink   (input valid, result_word, compare_true, divide_error,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/fixed_point_alu_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed Q24.8 fixed-point ALU: add, sub, mul, div, neg, inc, dec, six
// compares, min, max and integer conversions on 32-bit raw words.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one beat per operation (action, operand_a, operand_b).
//   rsp : one beat per command, in command order (result_word,
//         compare_true, divide_error).
//   A new command beat is taken every cycle while rsp does not stall;
//   throughput is one beat per cycle for every action, multiply and
//   divide included. Every action travels through the queue, the
//   multiply/entry stage, 40 divide stages of one quotient bit each,
//   and the output register, so order is kept.
//   When rsp stalls the whole back pipeline holds; the four-entry queue
//   keeps taking beats until it fills, then cmd.ready drops.
//   Reset clears the queue and all valid bits; no state survives between
//   operations. Divide by zero gives zero with divide_error set.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit (
    input  logic      clk,
    input  logic      rst_n,
    fpa_cmd_if.sink   cmd,
    fpa_rsp_if.source rsp
);
    import fpa_pkg::*;

    fpa_item_t          f_item;
    logic               f_valid;
    logic               f_ready;
    fpa_item_t          b_item;
    logic               b_valid;
    logic               b_ready;
    logic [Q_CNT_W-1:0] q_level;

    fpa_front u_front (
        .cmd        (cmd),
        .item       (f_item),
        .item_valid (f_valid),
        .item_ready (f_ready)
    );

    fpa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (f_item),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_item   (b_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .level      (q_level)
    );

    fpa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (b_item),
        .item_valid (b_valid),
        .item_ready (b_ready),
        .rsp        (rsp)
    );

    // a compare and a divide error never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> !(rsp.compare_true && rsp.divide_error))
        else $error("compare and divide error both set");

    // a divide error always returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.divide_error |-> rsp.result_word == 0)
        else $error("divide error with nonzero result");

    // queue full exactly when command side is back-pressured
    assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> q_level == Q_CNT_W'(Q_DEPTH))
        else $error("command stalled with room in queue");

    // a stalled back end does not let the queue drain
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready && !cmd.valid |=> q_level == $past(q_level))
        else $error("queue drained during output stall");

endmodule
`default_nettype wire

FILE: rtl/fpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_front
// Decodes a command beat: finishes the simple actions and prepares
// operands and sign for the multiply and divide units.
// ----------------------------------------------------------------------------
module fpa_front (
    fpa_cmd_if.sink            cmd,
    output fpa_pkg::fpa_item_t item,
    output logic               item_valid,
    input  logic               item_ready
);
    import fpa_pkg::*;

    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic                     lt;
    logic                     eq;

    assign a          = cmd.operand_a;
    assign b          = cmd.operand_b;
    assign lt         = a < b;
    assign eq         = a == b;
    assign item_valid = cmd.valid;
    assign cmd.ready  = item_ready;

    // classify and compute the simple results
    always_comb
    begin
        item      = '0;
        item.kind = KIND_ALU;
        item.a    = a;
        item.b    = b;
        item.dvd  = a[WORD_W-1] ? (WORD_W'(0) - a) : a;
        item.dvs  = b[WORD_W-1] ? (WORD_W'(0) - b) : b;
        item.neg  = a[WORD_W-1] ^ b[WORD_W-1];
        unique case (cmd.action)
            ACT_ADD:      item.res = a + b;
            ACT_SUB:      item.res = a - b;
            ACT_MUL:      item.kind = KIND_MUL;
            ACT_DIV:
            begin
                item.kind = KIND_DIV;
                item.derr = (b == '0);
            end
            ACT_NEG:      item.res = WORD_W'(0) - a;
            ACT_INC:      item.res = a + WORD_W'(1);
            ACT_DEC:      item.res = a - WORD_W'(1);
            ACT_EQ:       item.cmp = eq;
            ACT_NE:       item.cmp = !eq;
            ACT_GE:       item.cmp = !lt;
            ACT_LE:       item.cmp = lt || eq;
            ACT_GT:       item.cmp = !lt && !eq;
            ACT_LT:       item.cmp = lt;
            ACT_MIN:      item.res = (!lt && !eq) ? b : a;
            ACT_MAX:      item.res = lt ? b : a;
            ACT_FROM_INT: item.res = a << FRAC_BITS;
            ACT_TO_INT:   item.res = a >>> FRAC_BITS;
            default:      item.res = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/fpa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_queue
// Short FIFO of decoded items between front and back end.
// ----------------------------------------------------------------------------
module fpa_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  fpa_pkg::fpa_item_t push_item,
    input  logic               push_valid,
    output logic               push_ready,
    output fpa_pkg::fpa_item_t pop_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output logic [fpa_pkg::Q_CNT_W-1:0] level
);
    import fpa_pkg::*;

    fpa_item_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = cnt_reg != Q_CNT_W'(Q_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign level      = cnt_reg;

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + Q_CNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - Q_CNT_W'(1);
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

FILE: rtl/fpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa_back
// Execution pipeline: registered multiplier, one restoring divide step per
// stage, and the output register. All stages advance together.
// ----------------------------------------------------------------------------
module fpa_back (
    input  logic               clk,
    input  logic               rst_n,
    input  fpa_pkg::fpa_item_t item,
    input  logic               item_valid,
    output logic               item_ready,
    fpa_rsp_if.source          rsp
);
    import fpa_pkg::*;

    typedef struct packed {
        kind_t              kind;
        logic [WORD_W-1:0]  res;
        logic               cmp;
        logic               derr;
        logic               neg;
        logic [WORD_W-1:0]  dvs;
        logic [WORD_W-1:0]  rem;
        logic [DIV_W-1:0]   dq;   // dividend bits shift out, quotient in
    } stage_t;

    stage_t                 stg_reg  [DIV_W+1];
    stage_t                 stg_next [DIV_W+1];
    logic                   vld_reg  [DIV_W+1];
    logic signed [2*WORD_W-1:0] prod_reg;
    logic signed [2*WORD_W-1:0] prod_sh;
    logic                   adv;
    logic [WORD_W-1:0]      quo;
    logic                   out_vld_reg;
    logic [WORD_W-1:0]      out_res_reg;
    logic                   out_cmp_reg;
    logic                   out_derr_reg;

    assign adv        = !out_vld_reg || rsp.ready;
    assign item_ready = adv;
    assign prod_sh    = prod_reg >>> FRAC_BITS;
    assign quo        = stg_reg[DIV_W].dq[WORD_W-1:0];

    // stage inputs: entry load, multiply result into the first step, then one divide step per stage
    always_comb
    begin
        logic [WORD_W:0] rsh;
        stg_next[0]      = '0;
        stg_next[0].kind = item.kind;
        stg_next[0].res  = item.res;
        stg_next[0].cmp  = item.cmp;
        stg_next[0].derr = item.derr;
        stg_next[0].neg  = item.neg;
        stg_next[0].dvs  = item.dvs;
        stg_next[0].dq   = {item.dvd, {FRAC_BITS{1'b0}}};
        for (int k = 1; k <= DIV_W; k++)
        begin
            stg_next[k] = stg_reg[k-1];
            if (k == 1 && stg_reg[0].kind == KIND_MUL)
                stg_next[k].res = prod_sh[WORD_W-1:0];
            rsh = {stg_reg[k-1].rem, stg_reg[k-1].dq[DIV_W-1]};
            if (rsh >= {1'b0, stg_reg[k-1].dvs})
            begin
                rsh = rsh - {1'b0, stg_reg[k-1].dvs};
                stg_next[k].dq = {stg_reg[k-1].dq[DIV_W-2:0], 1'b1};
            end
            else
            begin
                stg_next[k].dq = {stg_reg[k-1].dq[DIV_W-2:0], 1'b0};
            end
            stg_next[k].rem = rsh[WORD_W-1:0];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= item.a * item.b;
            for (int k = 0; k <= DIV_W; k++)
                stg_reg[k] <= stg_next[k];
            out_cmp_reg  <= stg_reg[DIV_W].cmp;
            out_derr_reg <= stg_reg[DIV_W].derr;
            if (stg_reg[DIV_W].kind == KIND_DIV)
            begin
                if (stg_reg[DIV_W].derr)
                    out_res_reg <= '0;
                else if (stg_reg[DIV_W].neg)
                    out_res_reg <= WORD_W'(0) - quo;
                else
                    out_res_reg <= quo;
            end
            else
            begin
                out_res_reg <= stg_reg[DIV_W].res;
            end
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_W; k++)
                vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= item_valid;
            for (int k = 1; k <= DIV_W; k++)
                vld_reg[k] <= vld_reg[k-1];
            out_vld_reg <= vld_reg[DIV_W];
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.result_word  = out_res_reg;
    assign rsp.compare_true = out_cmp_reg;
    assign rsp.divide_error = out_derr_reg;

endmodule
`default_nettype wire

FILE: sim/tb_fixed_point_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_unit
// Drives command beats into the fixed-point ALU (directed corner cases, then
// random actions and operands with random idle cycles on both channels) and
// checks every response beat, in order, against a behavioral prediction.
// ----------------------------------------------------------------------------
import fpa_pkg::*;

typedef struct packed {
    logic [31:0] word;
    logic        cmp;
    logic        derr;
} alu_answer_t;

class alu_scoreboard;
    alu_answer_t pending[$];
    int          mismatches;

    function new();
        mismatches = 0;
    endfunction

    // behavioral fixed-point ALU
    static function alu_answer_t compute(logic [4:0] act, logic signed [31:0] a,
                                         logic signed [31:0] b);
        alu_answer_t      r;
        logic signed [63:0] prod;
        logic [63:0]      ma;
        logic [63:0]      mb;
        logic [63:0]      q;
        r = '0;
        case (act)
            ACT_ADD: r.word = a + b;
            ACT_SUB: r.word = a - b;
            ACT_MUL:
            begin
                prod = 64'(a) * 64'(b);
                prod = prod >>> FRAC_BITS;
                r.word = prod[31:0];
            end
            ACT_DIV:
            begin
                if (b == 0)
                    r.derr = 1'b1;
                else
                begin
                    ma = a < 0 ? -64'(a) : 64'(a);
                    mb = b < 0 ? -64'(b) : 64'(b);
                    q = (ma << FRAC_BITS) / mb;
                    if ((a < 0) != (b < 0))
                        q = -q;
                    r.word = q[31:0];
                end
            end
            ACT_NEG:      r.word = -a;
            ACT_INC:      r.word = a + 1;
            ACT_DEC:      r.word = a - 1;
            ACT_EQ:       r.cmp = (a == b);
            ACT_NE:       r.cmp = (a != b);
            ACT_GE:       r.cmp = (a >= b);
            ACT_LE:       r.cmp = (a <= b);
            ACT_GT:       r.cmp = (a > b);
            ACT_LT:       r.cmp = (a < b);
            ACT_MIN:      r.word = (a > b) ? b : a;
            ACT_MAX:      r.word = (a < b) ? b : a;
            ACT_FROM_INT: r.word = a << FRAC_BITS;
            ACT_TO_INT:   r.word = a >>> FRAC_BITS;
            default:      r = '0;
        endcase
        return r;
    endfunction

    function void note_command(logic [4:0] act, logic signed [31:0] a,
                               logic signed [31:0] b);
        pending.push_back(compute(act, a, b));
    endfunction

    function void check_response(alu_answer_t got);
        alu_answer_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected response beat %h", got);
            return;
        end
        want = pending.pop_front();
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: word exp %h got %h, cmp exp %b got %b, derr exp %b got %b",
                         want.word, got.word, want.cmp, got.cmp, want.derr, got.derr);
        end
    endfunction
endclass

module tb_fixed_point_alu_unit;
    localparam int WATCHDOG = 5000;

    logic clk;
    logic rst_n;
    logic quiet;   // no idling stretch
    int   stall_cycles;
    alu_scoreboard sb;

    fpa_cmd_if cmd ();
    fpa_rsp_if rsp ();

    fixed_point_alu_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd.sink),
        .rsp   (rsp.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'(int'($urandom_range(0, 4))) - 2;
            3: return 32'(int'($urandom_range(0, 8191))) - 4096;
            4: return 32'($urandom_range(0, 65535)) << FRAC_BITS;
            default: return $urandom;
        endcase
    endfunction

    // one command beat, held until accepted
    task automatic send_command(logic [4:0] act, logic signed [31:0] a,
                                logic signed [31:0] b);
        while (!quiet && $urandom_range(0, 99) < 6)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.action    <= act;
        cmd.operand_a <= a;
        cmd.operand_b <= b;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sb.note_command(act, a, b);
    endtask

    // response side: random backpressure, check each beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
                sb.check_response({rsp.result_word, rsp.compare_true, rsp.divide_error});
            rsp.ready <= quiet || ($urandom_range(0, 99) >= 6);
        end
    end

    // watchdog on cycles with no beat moved
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [4:0] act;
        int         k;
        sb = new();
        quiet = 1'b0;
        stall_cycles = 0;
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.action = '0;
        cmd.operand_a = '0;
        cmd.operand_b = '0;
        rsp.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every action on extremes, divide by zero, signed divides, equal min/max, unused code
        for (int i = 0; i <= 16; i++)
            send_command(5'(i), 32'sh7fffffff, 32'sh80000000);
        send_command(ACT_DIV, 32'sh00000100, 32'sh0);
        send_command(ACT_DIV, 32'sh80000000, -32'sh1);
        send_command(ACT_DIV, -32'sh300, 32'sh200);
        send_command(ACT_MIN, 32'sh55, 32'sh55);
        send_command(ACT_MAX, -32'sh7, -32'sh7);
        send_command(ACT_MUL, 32'sh80000000, 32'sh80000000);
        send_command(ACT_TO_INT, -32'sh1, 32'sh0);
        send_command(5'd31, 32'sh1234, 32'sh5678);

        // random: unused codes, zero divisors and equal operands mixed in, with a quiet stretch in the middle
        for (k = 0; k < 750; k++)
        begin
            quiet = (k >= 300 && k < 420);
            if ($urandom_range(0, 19) == 0)
                act = 5'($urandom_range(17, 31));
            else
                act = 5'($urandom_range(0, 16));
            if (act == ACT_DIV && $urandom_range(0, 9) == 0)
                send_command(act, pick_operand(), 32'sh0);
            else if ($urandom_range(0, 9) == 0)
            begin
                logic signed [31:0] v;
                v = pick_operand();
                send_command(act, v, v);
            end
            else
                send_command(act, pick_operand(), pick_operand());
        end
        cmd.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
